>>> design/ole_pkg.sv
// Shared types and constants for the ordered list engine.
package ole_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int VALUE_W          = 32;
    localparam int COUNT_W          = 5;

    // Both internal queues hold two words.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [1:0] {
        CMD_INS_FRONT = 2'd0,
        CMD_INS_BACK  = 2'd1,
        CMD_REMOVE    = 2'd2,
        CMD_CLEAR     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // A decoded command as it travels from the front part to the back part.
    typedef struct packed {
        logic               ins_front;
        logic               ins_back;
        logic               remove;
        logic               clear;
        logic [VALUE_W-1:0] value;
    } op_t;

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
    } result_t;

endpackage

>>> design/ordered_list_engine_unit.sv
// Ordered list engine: a bounded list of 32-bit values driven through a command queue.
//
// Usage:
//   Commands enter as words on a queue-style port: a word is taken at a clock
//   edge where push is high and full is low. Each word carries a command
//   (insert front, insert back, remove first match, clear) and a value.
//   Every command yields exactly one result word (status, count, is_empty)
//   on the result port, which also behaves like a queue: the oldest result
//   is shown while empty is low and is taken at an edge where pop is high.
//   A taken command waits in the command queue until the back part executes
//   it, which it does when the result queue has room; the result word is
//   then written to the result queue. Throughput: one command per cycle
//   while the result queue has room. The cell list compares and shifts
//   all entries in parallel, so even remove needs no serial search.
//   Reset empties the list and both internal two-word queues; entry contents
//   are not cleared, since no entry is read before it is written.
//   When pop stays low the result queue fills after two words, the back part
//   stops, and the command queue then raises full after two more words.
module ordered_list_engine_unit
#(
    parameter int CAPACITY = ole_pkg::DEFAULT_CAPACITY
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  command,
    input  logic [ole_pkg::VALUE_W-1:0] value,
    output logic                        empty,
    input  logic                        pop,
    output logic [1:0]                  status,
    output logic [ole_pkg::COUNT_W-1:0] count,
    output logic                        is_empty
);

    logic             op_valid;
    logic             op_take;
    ole_pkg::op_t     op;
    ole_pkg::result_t res;

    ole_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .command  (command),
        .value    (value),
        .op_valid (op_valid),
        .op       (op),
        .op_take  (op_take)
    );

    ole_back
    #(
        .CAPACITY (CAPACITY)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op       (op),
        .op_take  (op_take),
        .empty    (empty),
        .pop      (pop),
        .res      (res)
    );

    assign status   = res.status;
    assign count    = res.count;
    assign is_empty = res.is_empty;

endmodule

>>> design/ole_front.sv
// Front part: accepts command words, decodes them and queues them for the back part.
module ole_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  command,
    input  logic [ole_pkg::VALUE_W-1:0] value,
    output logic                        op_valid,
    output ole_pkg::op_t                op,
    input  logic                        op_take
);

    ole_pkg::op_t                 q_reg [ole_pkg::Q_DEPTH];
    logic [ole_pkg::Q_PTR_W-1:0]  wr_ptr_reg;
    logic [ole_pkg::Q_PTR_W-1:0]  wr_ptr_next;
    logic [ole_pkg::Q_PTR_W-1:0]  rd_ptr_reg;
    logic [ole_pkg::Q_PTR_W-1:0]  rd_ptr_next;
    logic [ole_pkg::Q_CNT_W-1:0]  cnt_reg;
    logic [ole_pkg::Q_CNT_W-1:0]  cnt_next;
    ole_pkg::op_t                 decoded;
    logic                         accept;
    logic                         take;

    always_comb
    begin
        decoded       = '0;
        decoded.value = value;
        unique case (ole_pkg::cmd_t'(command))
            ole_pkg::CMD_INS_FRONT: decoded.ins_front = 1'b1;
            ole_pkg::CMD_INS_BACK:  decoded.ins_back  = 1'b1;
            ole_pkg::CMD_REMOVE:    decoded.remove    = 1'b1;
            ole_pkg::CMD_CLEAR:     decoded.clear     = 1'b1;
            default:                decoded.clear     = 1'b1;
        endcase
    end

    assign full     = (cnt_reg == ole_pkg::Q_CNT_W'(ole_pkg::Q_DEPTH));
    assign op_valid = (cnt_reg != '0);
    assign op       = q_reg[rd_ptr_reg];
    assign accept   = push && !full;
    assign take     = op_take && op_valid;

    always_comb
    begin
        wr_ptr_next = accept ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (accept && !take)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (take && !accept)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

>>> design/ole_back.sv
// Back part: the shift-register cell list that executes commands and queues results.
module ole_back
#(
    parameter int CAPACITY = ole_pkg::DEFAULT_CAPACITY
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        op_valid,
    input  ole_pkg::op_t                op,
    output logic                        op_take,
    output logic                        empty,
    input  logic                        pop,
    output ole_pkg::result_t            res
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = LEN_W + ole_pkg::COUNT_W;

    logic [ole_pkg::VALUE_W-1:0]  cell_reg  [CAPACITY];
    logic [ole_pkg::VALUE_W-1:0]  cell_next [CAPACITY];
    logic [LEN_W-1:0]             len_reg;
    logic [LEN_W-1:0]             len_next;
    logic [EXT_W-1:0]             len_ext;
    logic [CAPACITY-1:0]          match;
    logic [CAPACITY-1:0]          hit;
    logic                         list_full;
    logic                         list_zero;
    logic                         exec;
    logic                         do_front;
    logic                         do_back;
    logic                         do_remove;
    ole_pkg::status_t             status;
    ole_pkg::result_t             res_new;

    ole_pkg::result_t             rq_reg [ole_pkg::Q_DEPTH];
    logic [ole_pkg::Q_PTR_W-1:0]  rq_wr_reg;
    logic [ole_pkg::Q_PTR_W-1:0]  rq_rd_reg;
    logic [ole_pkg::Q_CNT_W-1:0]  rq_cnt_reg;
    logic [ole_pkg::Q_CNT_W-1:0]  rq_cnt_next;
    logic                         rq_full;
    logic                         res_take;

    assign rq_full  = (rq_cnt_reg == ole_pkg::Q_CNT_W'(ole_pkg::Q_DEPTH));
    assign empty    = (rq_cnt_reg == '0);
    assign res      = rq_reg[rq_rd_reg];
    assign res_take = pop && !empty;
    assign exec     = op_valid && !rq_full;
    assign op_take  = exec;

    assign list_full = (len_reg == LEN_W'(CAPACITY));
    assign list_zero = (len_reg == '0);

    // Every valid cell compares against the search value at once; the first
    // match and every cell behind it form a contiguous run, found with x | -x.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            match[i] = (LEN_W'(i) < len_reg) && (cell_reg[i] == op.value);
        end
        hit = match | (~match + CAPACITY'(1));
    end

    always_comb
    begin
        status    = ole_pkg::ST_OK;
        len_next  = len_reg;
        do_front  = 1'b0;
        do_back   = 1'b0;
        do_remove = 1'b0;
        if (op.ins_front || op.ins_back)
        begin
            if (list_full)
            begin
                status = ole_pkg::ST_FULL;
            end
            else
            begin
                len_next = len_reg + 1'b1;
                do_front = op.ins_front;
                do_back  = op.ins_back;
            end
        end
        else if (op.remove)
        begin
            if (!hit[CAPACITY-1])
            begin
                status = ole_pkg::ST_NOTFOUND;
            end
            else
            begin
                len_next  = len_reg - 1'b1;
                do_remove = 1'b1;
            end
        end
        else
        begin
            if (list_zero)
            begin
                status = ole_pkg::ST_EMPTY;
            end
            else
            begin
                len_next = '0;
            end
        end
    end

    assign len_ext          = EXT_W'(len_next);
    assign res_new.status   = status;
    assign res_new.count    = len_ext[ole_pkg::COUNT_W-1:0];
    assign res_new.is_empty = (len_next == '0);

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        always_comb
        begin
            cell_next[g] = cell_reg[g];
            if (do_front)
            begin
                if (g == 0)
                begin
                    cell_next[g] = op.value;
                end
                else
                begin
                    cell_next[g] = cell_reg[(g == 0) ? 0 : g - 1];
                end
            end
            else if (do_back)
            begin
                if (LEN_W'(g) == len_reg)
                begin
                    cell_next[g] = op.value;
                end
            end
            else if (do_remove)
            begin
                if (hit[g] && (g < CAPACITY - 1))
                begin
                    cell_next[g] = cell_reg[(g < CAPACITY - 1) ? g + 1 : g];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (exec)
            begin
                cell_reg[g] <= cell_next[g];
            end
        end
    end

    always_comb
    begin
        rq_cnt_next = rq_cnt_reg;
        if (exec && !res_take)
        begin
            rq_cnt_next = rq_cnt_reg + 1'b1;
        end
        else if (res_take && !exec)
        begin
            rq_cnt_next = rq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            rq_wr_reg  <= '0;
            rq_rd_reg  <= '0;
            rq_cnt_reg <= '0;
        end
        else
        begin
            if (exec)
            begin
                len_reg   <= len_next;
                rq_wr_reg <= rq_wr_reg + 1'b1;
            end
            if (res_take)
            begin
                rq_rd_reg <= rq_rd_reg + 1'b1;
            end
            rq_cnt_reg <= rq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            rq_reg[rq_wr_reg] <= res_new;
        end
    end

endmodule

>>> design/ole_checker.sv
// Port-level checks for the ordered list engine, bound to the top level.
module ole_checker
#(
    parameter int CAPACITY = ole_pkg::DEFAULT_CAPACITY
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        empty,
    input  logic                        pop,
    input  logic [1:0]                  status,
    input  logic [ole_pkg::COUNT_W-1:0] count,
    input  logic                        is_empty
);

    localparam int EXT_W = 32 + ole_pkg::COUNT_W;
    localparam logic [EXT_W-1:0] CAP_EXT = EXT_W'(CAPACITY);
    localparam logic [ole_pkg::COUNT_W-1:0] CAP_COUNT = CAP_EXT[ole_pkg::COUNT_W-1:0];

    // The empty flag must agree with the count it travels with.
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (is_empty == (count == '0)))
        else $error("is_empty disagrees with count");

    // A refused insert leaves the list at capacity.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == ole_pkg::ST_FULL)) |-> (count == CAP_COUNT))
        else $error("full refusal with count below capacity");

    // Clearing an empty list leaves it empty.
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == ole_pkg::ST_EMPTY)) |-> (is_empty && (count == '0)))
        else $error("already-empty status on a non-empty list");

    // A result word that is not taken holds still.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(count)
                              && $stable(is_empty)))
        else $error("waiting result word changed");

endmodule

bind ordered_list_engine_unit ole_checker #(.CAPACITY(CAPACITY)) u_ole_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .status   (status),
    .count    (count),
    .is_empty (is_empty)
);
